[sv/ffc_pkg.sv]
// Package for the forest fire cell update block.
// Holds request, cell and register codes, the sequencer state type and the
// neighbour offset table. No dependencies.
package ffc_pkg;

  localparam int REQ_W     = 2;
  localparam int CELL_W    = 3;
  localparam int THR_W     = 17;
  localparam int DENSE_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 17;
  localparam int K_W       = 4;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd2;

  // Cell state codes.
  localparam logic [CELL_W-1:0] CELL_YOUNG  = 3'd0;
  localparam logic [CELL_W-1:0] CELL_MATURE = 3'd1;
  localparam logic [CELL_W-1:0] CELL_START  = 3'd2;
  localparam logic [CELL_W-1:0] CELL_BURN   = 3'd3;
  localparam logic [CELL_W-1:0] CELL_END    = 3'd4;
  localparam logic [CELL_W-1:0] CELL_ASHES  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IGN_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGN_BURN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGN_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATURE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPONT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSE_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BURN_PROG = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REGROW    = 3'd7;

  // Register reset values.
  localparam logic [THR_W-1:0]   RST_IGN_START = 17'd10000;
  localparam logic [THR_W-1:0]   RST_IGN_BURN  = 17'd20000;
  localparam logic [THR_W-1:0]   RST_IGN_END   = 17'd10000;
  localparam logic [THR_W-1:0]   RST_MATURE    = 17'd500;
  localparam logic [THR_W-1:0]   RST_SPONT     = 17'd5;
  localparam logic [DENSE_W-1:0] RST_DENSE_MIN = 4'd5;
  localparam logic [THR_W-1:0]   RST_BURN_PROG = 17'd10000;
  localparam logic [THR_W-1:0]   RST_REGROW    = 17'd200;

  // Scan step of the last neighbour; step 0 is the addressed cell itself.
  localparam logic [K_W-1:0] K_CENTER = 4'd0;
  localparam logic [K_W-1:0] K_LAST   = 4'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic signed [1:0] dr;
    logic signed [1:0] dc;
  } nb_ofs_t;

  function automatic nb_ofs_t nb_ofs(input logic [K_W-1:0] k);
    nb_ofs_t o;
    unique case (k)
      4'd1:    o = '{dr: -2'sd1, dc: -2'sd1};
      4'd2:    o = '{dr: -2'sd1, dc:  2'sd0};
      4'd3:    o = '{dr: -2'sd1, dc:  2'sd1};
      4'd4:    o = '{dr:  2'sd0, dc: -2'sd1};
      4'd5:    o = '{dr:  2'sd0, dc:  2'sd1};
      4'd6:    o = '{dr:  2'sd1, dc: -2'sd1};
      4'd7:    o = '{dr:  2'sd1, dc:  2'sd0};
      4'd8:    o = '{dr:  2'sd1, dc:  2'sd1};
      default: o = '{dr:  2'sd0, dc:  2'sd0};
    endcase
    return o;
  endfunction

endpackage

[sv/forest_fire_cell_update.sv]
// Forest fire cell update block: grid memory, scan sequencer and cell rule.
// Depends on ffc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: write a cell,
//   read a cell, or update a cell in place from its eight neighbours and
//   the supplied draw. Every request gives exactly one result on the output
//   channel (out_valid / out_stall): the cell state after the request and a
//   changed flag, which only an update can raise. Addresses outside the
//   grid store nothing and return young, unchanged.
//   Configuration (cfg_we / cfg_index / cfg_wdata) writes one threshold
//   register per cycle; write it only while no request is in flight.
// Sequencing:
//   The grid is one single-port-read, single-port-write memory with a
//   registered read port. An update reads the cell and its eight
//   neighbours one per cycle, read and write requests only the cell; a
//   drain state and a final state follow, and out-of-grid requests go from
//   accept straight to the final state. The next request is accepted only
//   once the final state has handed its result to the output register.
// Reset:
//   rst_n low restores the register defaults. After reset a clearing pass
//   writes every cell to young, one cell a cycle; in_stall stays high
//   until it ends.
// Stall:
//   A finished result sits in the output register while out_stall is high.
//   The next request is still accepted and scanned; it waits at its write
//   back until the output register frees.
module forest_fire_cell_update #(
  parameter int ROWS = 64,
  parameter int COLS = 64,
  localparam int RW  = $clog2(ROWS),
  localparam int CW  = $clog2(COLS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffc_pkg::REQ_W-1:0]     in_req_type,
  input  logic [RW-1:0]                 in_row_index,
  input  logic [CW-1:0]                 in_col_index,
  input  logic [ffc_pkg::CELL_W-1:0]    in_new_state,
  input  logic [ffc_pkg::THR_W-1:0]     in_draw,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffc_pkg::CELL_W-1:0]    out_cell_state,
  output logic                          out_changed,
  // configuration port
  input  logic                          cfg_we,
  input  logic [ffc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffc_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0]        CLR_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0]        COLS_A   = AW'(COLS);
  localparam logic [RW:0]          ROWS_U   = (RW+1)'(ROWS);
  localparam logic [CW:0]          COLS_U   = (CW+1)'(COLS);
  localparam logic signed [RW+1:0] ROWS_S   = (RW+2)'(ROWS);
  localparam logic signed [CW+1:0] COLS_S   = (CW+2)'(COLS);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ffc_pkg::THR_W-1:0]   ign_start_r, ign_burn_r, ign_end_r;
  logic [ffc_pkg::THR_W-1:0]   mature_r, spont_r, burn_prog_r, regrow_r;
  logic [ffc_pkg::DENSE_W-1:0] dense_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ign_start_r <= ffc_pkg::RST_IGN_START;
      ign_burn_r  <= ffc_pkg::RST_IGN_BURN;
      ign_end_r   <= ffc_pkg::RST_IGN_END;
      mature_r    <= ffc_pkg::RST_MATURE;
      spont_r     <= ffc_pkg::RST_SPONT;
      dense_min_r <= ffc_pkg::RST_DENSE_MIN;
      burn_prog_r <= ffc_pkg::RST_BURN_PROG;
      regrow_r    <= ffc_pkg::RST_REGROW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffc_pkg::CFG_IGN_START: ign_start_r <= cfg_wdata;
        ffc_pkg::CFG_IGN_BURN:  ign_burn_r  <= cfg_wdata;
        ffc_pkg::CFG_IGN_END:   ign_end_r   <= cfg_wdata;
        ffc_pkg::CFG_MATURE:    mature_r    <= cfg_wdata;
        ffc_pkg::CFG_SPONT:     spont_r     <= cfg_wdata;
        ffc_pkg::CFG_DENSE_MIN: dense_min_r <= cfg_wdata[ffc_pkg::DENSE_W-1:0];
        ffc_pkg::CFG_BURN_PROG: burn_prog_r <= cfg_wdata;
        ffc_pkg::CFG_REGROW:    regrow_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  ffc_pkg::state_t           state_r, state_nxt;
  logic [AW-1:0]             clr_r;
  logic [ffc_pkg::K_W-1:0]   k_r;
  logic                      rd_pend_r;
  logic [ffc_pkg::K_W-1:0]   rd_k_r;
  logic                      out_valid_r;

  // request held for the scan
  logic [ffc_pkg::REQ_W-1:0]  req_r;
  logic [RW-1:0]              row_r;
  logic [CW-1:0]              col_r;
  logic [ffc_pkg::CELL_W-1:0] ns_r;
  logic [ffc_pkg::THR_W-1:0]  draw_r;
  logic                       inr_r;

  // gathered neighbourhood
  logic [ffc_pkg::CELL_W-1:0]  cur_r;
  logic                        f_start_r, f_burn_r, f_end_r;
  logic [ffc_pkg::DENSE_W-1:0] n_mature_r;

  // output register
  logic [ffc_pkg::CELL_W-1:0] out_cell_state_r;
  logic                       out_changed_r;

  // sequencer outputs
  logic accept, scan_step, out_free, out_load, k_done;
  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [ffc_pkg::CELL_W-1:0] wr_data;

  // ---------------------------------------------------------------------
  // Grid memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic [ffc_pkg::CELL_W-1:0] grid [DEPTH];
  logic [ffc_pkg::CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= grid[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Neighbour address for the current scan step
  // ---------------------------------------------------------------------
  ffc_pkg::nb_ofs_t       ofs;
  logic signed [RW+1:0]   nr_s;
  logic signed [CW+1:0]   nc_s;
  logic                   nb_ok;
  logic [AW-1:0]          nb_addr, ctr_addr;
  logic                   in_inr;

  assign ofs   = ffc_pkg::nb_ofs(k_r);
  assign nr_s  = $signed({2'b00, row_r}) + (RW+2)'(ofs.dr);
  assign nc_s  = $signed({2'b00, col_r}) + (CW+2)'(ofs.dc);
  assign nb_ok = !nr_s[RW+1] && (nr_s < ROWS_S) && !nc_s[CW+1] && (nc_s < COLS_S);
  assign nb_addr  = AW'(nr_s[RW-1:0]) * COLS_A + AW'(nc_s[CW-1:0]);
  assign ctr_addr = AW'(row_r) * COLS_A + AW'(col_r);

  assign in_inr = ({1'b0, in_row_index} < ROWS_U) && ({1'b0, in_col_index} < COLS_U);

  // Reads and writes stay only for the addressed cell; neighbours are read-only.
  assign k_done = (k_r == ((req_r == ffc_pkg::REQ_UPDATE) ? ffc_pkg::K_LAST
                                                          : ffc_pkg::K_CENTER));

  // ---------------------------------------------------------------------
  // Cell rule and result
  // ---------------------------------------------------------------------
  logic [ffc_pkg::CELL_W-1:0] rule_nxt, res_state;
  logic                       res_changed, res_we;

  always_comb begin
    rule_nxt = cur_r;
    unique case (cur_r)
      ffc_pkg::CELL_YOUNG, ffc_pkg::CELL_MATURE: begin
        // fire nearby takes priority, earliest stage of burn first
        priority if (f_start_r) begin
          if (draw_r < ign_start_r) rule_nxt = ffc_pkg::CELL_START;
        end else if (f_burn_r) begin
          if (draw_r < ign_burn_r) rule_nxt = ffc_pkg::CELL_START;
        end else if (f_end_r) begin
          if (draw_r < ign_end_r) rule_nxt = ffc_pkg::CELL_START;
        end else if (cur_r == ffc_pkg::CELL_YOUNG) begin
          if (draw_r < mature_r) rule_nxt = ffc_pkg::CELL_MATURE;
        end else begin
          if ((n_mature_r >= dense_min_r) && (draw_r < spont_r)) begin
            rule_nxt = ffc_pkg::CELL_START;
          end
        end
      end
      ffc_pkg::CELL_START: begin
        if (draw_r < burn_prog_r) rule_nxt = ffc_pkg::CELL_BURN;
      end
      ffc_pkg::CELL_BURN: begin
        if (draw_r < burn_prog_r) rule_nxt = ffc_pkg::CELL_END;
      end
      ffc_pkg::CELL_END: begin
        if (draw_r < burn_prog_r) rule_nxt = ffc_pkg::CELL_ASHES;
      end
      ffc_pkg::CELL_ASHES: begin
        if (draw_r < regrow_r) rule_nxt = ffc_pkg::CELL_YOUNG;
      end
      default: rule_nxt = cur_r;
    endcase
  end

  always_comb begin
    res_state   = cur_r;
    res_changed = 1'b0;
    res_we      = 1'b0;
    if (!inr_r) begin
      // outside the grid: nothing stored, young reported
      res_state = ffc_pkg::CELL_YOUNG;
    end else begin
      unique case (req_r)
        ffc_pkg::REQ_WRITE: begin
          // drop writes of codes that name no state
          if (ns_r <= ffc_pkg::CELL_ASHES) begin
            res_state = ns_r;
            res_we    = 1'b1;
          end
        end
        ffc_pkg::REQ_UPDATE: begin
          res_state   = rule_nxt;
          res_changed = (rule_nxt != cur_r);
          res_we      = 1'b1;
        end
        default: res_state = cur_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffc_pkg::ST_CLEAR: if (clr_r == CLR_LAST) state_nxt = ffc_pkg::ST_IDLE;
      ffc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = in_inr ? ffc_pkg::ST_SCAN : ffc_pkg::ST_FIN;
      end
      ffc_pkg::ST_SCAN:  if (k_done) state_nxt = ffc_pkg::ST_DRAIN;
      ffc_pkg::ST_DRAIN: state_nxt = ffc_pkg::ST_FIN;
      ffc_pkg::ST_FIN:   if (out_free) state_nxt = ffc_pkg::ST_IDLE;
      default:           state_nxt = ffc_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    scan_step = 1'b0;
    out_load  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = nb_addr;
    wr_en     = 1'b0;
    wr_addr   = ctr_addr;
    wr_data   = res_state;
    unique case (state_r)
      ffc_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = ffc_pkg::CELL_YOUNG;
      end
      ffc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ffc_pkg::ST_SCAN: begin
        scan_step = 1'b1;
        rd_en     = nb_ok;
      end
      ffc_pkg::ST_DRAIN: ;
      ffc_pkg::ST_FIN: begin
        // write back and hand over the result in the same cycle
        out_load = out_free;
        wr_en    = out_free && res_we;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffc_pkg::ST_CLEAR;
      clr_r       <= '0;
      k_r         <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
      if (state_r == ffc_pkg::ST_CLEAR) clr_r <= clr_r + AW'(1);
      if (accept) begin
        k_r <= ffc_pkg::K_CENTER;
      end else if (scan_step) begin
        k_r <= k_r + ffc_pkg::K_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    rd_k_r <= k_r;
    if (accept) begin
      req_r      <= in_req_type;
      row_r      <= in_row_index;
      col_r      <= in_col_index;
      ns_r       <= in_new_state;
      draw_r     <= in_draw;
      inr_r      <= in_inr;
      f_start_r  <= 1'b0;
      f_burn_r   <= 1'b0;
      f_end_r    <= 1'b0;
      n_mature_r <= '0;
    end else if (rd_pend_r) begin
      // collect read data in the cycle after its address
      if (rd_k_r == ffc_pkg::K_CENTER) begin
        cur_r <= rd_data_r;
      end else begin
        unique case (rd_data_r)
          ffc_pkg::CELL_START:  f_start_r  <= 1'b1;
          ffc_pkg::CELL_BURN:   f_burn_r   <= 1'b1;
          ffc_pkg::CELL_END:    f_end_r    <= 1'b1;
          ffc_pkg::CELL_MATURE: n_mature_r <= n_mature_r + ffc_pkg::DENSE_W'(1);
          default: ;
        endcase
      end
    end
    if (out_load) begin
      out_cell_state_r <= res_state;
      out_changed_r    <= res_changed;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_state = out_cell_state_r;
  assign out_changed    = out_changed_r;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the forest fire cell update block.
// Drives write, read and update requests against a shadow grid and register set,
// compares every result in order. Depends on ffc_pkg and forest_fire_cell_update.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS           = 64;
  localparam int COLS           = 64;
  localparam int RW             = $clog2(ROWS);
  localparam int CW             = $clog2(COLS);
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 180;
  // Covers the clearing pass after reset plus the longest quiet stretch, with margin.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 24;
  localparam int THR_SCALE      = 100000;
  localparam int DRAW_MAX       = 99999;
  localparam int DENSE_ALL_NB   = 8;

  // Request code outside the documented set; the block treats it as a read.
  localparam logic [ffc_pkg::REQ_W-1:0]  REQ_SPARE  = 2'd3;
  // Cell codes that a write must refuse.
  localparam logic [ffc_pkg::CELL_W-1:0] CELL_BAD_A = 3'd6;
  localparam logic [ffc_pkg::CELL_W-1:0] CELL_BAD_B = 3'd7;

  typedef struct packed {
    logic [ffc_pkg::REQ_W-1:0]  kind;
    logic [RW-1:0]              row;
    logic [CW-1:0]              col;
    logic [ffc_pkg::CELL_W-1:0] st;
    logic [ffc_pkg::THR_W-1:0]  draw;
  } cell_req_t;

  typedef struct packed {
    logic [ffc_pkg::CELL_W-1:0] state;
    logic                       changed;
  } cell_result_t;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic [ffc_pkg::REQ_W-1:0]     in_req_type  = ffc_pkg::REQ_READ;
  logic [RW-1:0]                 in_row_index = '0;
  logic [CW-1:0]                 in_col_index = '0;
  logic [ffc_pkg::CELL_W-1:0]    in_new_state = ffc_pkg::CELL_YOUNG;
  logic [ffc_pkg::THR_W-1:0]     in_draw      = '0;
  logic                          out_valid;
  logic                          out_stall    = 1'b0;
  logic [ffc_pkg::CELL_W-1:0]    out_cell_state;
  logic                          out_changed;
  logic                          cfg_we       = 1'b0;
  logic [ffc_pkg::CFG_IDX_W-1:0] cfg_index    = ffc_pkg::CFG_IGN_START;
  logic [ffc_pkg::CFG_W-1:0]     cfg_wdata    = '0;

  // Shadow of the block: grid contents and register values as the block should hold them.
  logic [ffc_pkg::CELL_W-1:0] forest_model [ROWS][COLS];
  logic [ffc_pkg::CFG_W-1:0]  cfg_shadow [8];

  cell_req_t    pending_requests[$];
  cell_result_t predicted_cells[$];

  int   err_count     = 0;
  int   items_queued  = 0;
  int   idle_cycles   = 0;
  int   send_gap      = 0;
  int   hold_cycles   = 0;
  bit   idling_on     = 1'b1;
  logic req_taken     = 1'b0;

  forest_fire_cell_update #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_row_index  (in_row_index),
    .in_col_index  (in_col_index),
    .in_new_state  (in_new_state),
    .in_draw       (in_draw),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_state(out_cell_state),
    .out_changed   (out_changed),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cell rule: count the in-grid neighbours by state, then pick the transition.
  // Fire nearby wins over maturing and self-ignition, starting over burning
  // over ending. Draws compare strictly below the threshold.
  // ---------------------------------------------------------------------------
  function automatic logic [ffc_pkg::CELL_W-1:0] evolve_cell(
      input int row, input int col, input logic [ffc_pkg::THR_W-1:0] draw);
    int                         n_start;
    int                         n_burn;
    int                         n_end;
    int                         n_mature;
    int                         nr;
    int                         nc;
    logic [ffc_pkg::CELL_W-1:0] cur;
    n_start  = 0;
    n_burn   = 0;
    n_end    = 0;
    n_mature = 0;
    cur      = forest_model[row][col];
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = row + dr;
        nc = col + dc;
        // Skip the cell itself and anything past the grid border.
        if ((dr != 0 || dc != 0) && nr >= 0 && nr < ROWS && nc >= 0 && nc < COLS) begin
          case (forest_model[nr][nc])
            ffc_pkg::CELL_START:  n_start++;
            ffc_pkg::CELL_BURN:   n_burn++;
            ffc_pkg::CELL_END:    n_end++;
            ffc_pkg::CELL_MATURE: n_mature++;
            default: ;
          endcase
        end
      end
    end
    case (cur)
      ffc_pkg::CELL_YOUNG, ffc_pkg::CELL_MATURE: begin
        if (n_start > 0)
          return (draw < cfg_shadow[ffc_pkg::CFG_IGN_START]) ? ffc_pkg::CELL_START : cur;
        if (n_burn > 0)
          return (draw < cfg_shadow[ffc_pkg::CFG_IGN_BURN]) ? ffc_pkg::CELL_START : cur;
        if (n_end > 0)
          return (draw < cfg_shadow[ffc_pkg::CFG_IGN_END]) ? ffc_pkg::CELL_START : cur;
        if (cur == ffc_pkg::CELL_YOUNG)
          return (draw < cfg_shadow[ffc_pkg::CFG_MATURE]) ? ffc_pkg::CELL_MATURE : cur;
        // Self-ignition needs enough mature neighbours as well as a low draw.
        return (n_mature >= cfg_shadow[ffc_pkg::CFG_DENSE_MIN] &&
                draw < cfg_shadow[ffc_pkg::CFG_SPONT]) ? ffc_pkg::CELL_START : cur;
      end
      ffc_pkg::CELL_START:
        return (draw < cfg_shadow[ffc_pkg::CFG_BURN_PROG]) ? ffc_pkg::CELL_BURN : cur;
      ffc_pkg::CELL_BURN:
        return (draw < cfg_shadow[ffc_pkg::CFG_BURN_PROG]) ? ffc_pkg::CELL_END : cur;
      ffc_pkg::CELL_END:
        return (draw < cfg_shadow[ffc_pkg::CFG_BURN_PROG]) ? ffc_pkg::CELL_ASHES : cur;
      ffc_pkg::CELL_ASHES:
        return (draw < cfg_shadow[ffc_pkg::CFG_REGROW]) ? ffc_pkg::CELL_YOUNG : cur;
      default: return cur;
    endcase
  endfunction

  // Apply one accepted request to the shadow grid and return the result it owes.
  function automatic cell_result_t step_cell_grid(input cell_req_t rq);
    cell_result_t               res;
    logic [ffc_pkg::CELL_W-1:0] cur;
    logic [ffc_pkg::CELL_W-1:0] nxt;
    res.state   = ffc_pkg::CELL_YOUNG;
    res.changed = 1'b0;
    // Off-grid addresses store nothing and answer young, unchanged.
    if (rq.row < ROWS && rq.col < COLS) begin
      cur = forest_model[rq.row][rq.col];
      case (rq.kind)
        ffc_pkg::REQ_WRITE: begin
          // Refuse codes past ashes; the cell keeps what it had.
          if (rq.st <= ffc_pkg::CELL_ASHES) forest_model[rq.row][rq.col] = rq.st;
          res.state = forest_model[rq.row][rq.col];
        end
        ffc_pkg::REQ_UPDATE: begin
          nxt                          = evolve_cell(int'(rq.row), int'(rq.col), rq.draw);
          res.changed                  = (nxt != cur);
          forest_model[rq.row][rq.col] = nxt;
          res.state                    = nxt;
        end
        default: res.state = cur;  // read, and the spare code acts as a read
      endcase
    end
    return res;
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (!idling_on) return 0;
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Draws cluster at the live thresholds so both sides of each compare get hit.
  function automatic logic [ffc_pkg::THR_W-1:0] pick_draw();
    logic [ffc_pkg::THR_W-1:0] t;
    t = cfg_shadow[$urandom_range(0, 7)];
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ffc_pkg::THR_W'(DRAW_MAX);
      2:       return ffc_pkg::THR_W'($urandom_range(0, (1 << ffc_pkg::THR_W) - 1));
      3, 4:    return t - 1'b1;
      5:       return t;
      6:       return t + 1'b1;
      default: return ffc_pkg::THR_W'($urandom_range(0, DRAW_MAX));
    endcase
  endfunction

  function automatic logic [ffc_pkg::CFG_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ffc_pkg::CFG_W'(1);
      2:       return ffc_pkg::CFG_W'(DRAW_MAX);
      3:       return ffc_pkg::CFG_W'(THR_SCALE);
      4:       return '1;
      default: return ffc_pkg::CFG_W'($urandom_range(0, THR_SCALE));
    endcase
  endfunction

  function automatic logic [ffc_pkg::CELL_W-1:0] pick_state();
    return ffc_pkg::CELL_W'($urandom_range(ffc_pkg::CELL_YOUNG, ffc_pkg::CELL_ASHES));
  endfunction

  task automatic queue_request(input logic [ffc_pkg::REQ_W-1:0] kind, input int row,
                               input int col, input logic [ffc_pkg::CELL_W-1:0] st,
                               input logic [ffc_pkg::THR_W-1:0] draw);
    cell_req_t rq;
    rq.kind = kind;
    rq.row  = RW'(row);
    rq.col  = CW'(col);
    rq.st   = st;
    rq.draw = draw;
    pending_requests = {pending_requests, rq};
    items_queued++;
  endtask

  // Paint a neighbourhood around one cell, then update it a few times. Corners
  // and edges come up often so the short neighbour counts get exercised.
  task automatic queue_patch();
    int                         r;
    int                         c;
    int                         nr;
    int                         nc;
    int                         n_upd;
    logic [ffc_pkg::CELL_W-1:0] theme;
    logic [ffc_pkg::CELL_W-1:0] s;
    r = $urandom_range(0, ROWS - 1);
    c = $urandom_range(0, COLS - 1);
    case ($urandom_range(0, 5))
      0: r = $urandom_range(0, 1) ? 0 : ROWS - 1;
      1: c = $urandom_range(0, 1) ? 0 : COLS - 1;
      2: begin
        r = $urandom_range(0, 1) ? 0 : ROWS - 1;
        c = $urandom_range(0, 1) ? 0 : COLS - 1;
      end
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0:       theme = ffc_pkg::CELL_START;
      1:       theme = ffc_pkg::CELL_BURN;
      2:       theme = ffc_pkg::CELL_END;
      3:       theme = ffc_pkg::CELL_MATURE;
      default: theme = ffc_pkg::CELL_YOUNG;
    endcase
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = r + dr;
        nc = c + dc;
        // Leave some neighbours as they were to vary the counts.
        if ((dr != 0 || dc != 0) && nr >= 0 && nr < ROWS && nc >= 0 && nc < COLS &&
            $urandom_range(0, 4) != 0) begin
          s = $urandom_range(0, 1) ? theme : pick_state();
          queue_request(ffc_pkg::REQ_WRITE, nr, nc, s,
                        ffc_pkg::THR_W'($urandom_range(0, (1 << ffc_pkg::THR_W) - 1)));
        end
      end
    end
    s = $urandom_range(0, 1) ? pick_state() :
        ($urandom_range(0, 1) ? ffc_pkg::CELL_YOUNG : ffc_pkg::CELL_MATURE);
    queue_request(ffc_pkg::REQ_WRITE, r, c, s, pick_draw());
    n_upd = $urandom_range(1, 4);
    repeat (n_upd) queue_request(ffc_pkg::REQ_UPDATE, r, c, pick_state(), pick_draw());
    if ($urandom_range(0, 1)) queue_request(ffc_pkg::REQ_READ, r, c, pick_state(), pick_draw());
  endtask

  // Mostly patches; the rest is noise over every field value, spare code included.
  task automatic fill_random(input int budget);
    int target;
    target = items_queued + budget;
    while (items_queued < target) begin
      if ($urandom_range(0, 99) < 15)
        queue_request(ffc_pkg::REQ_W'($urandom_range(0, 3)), $urandom_range(0, ROWS - 1),
                      $urandom_range(0, COLS - 1), ffc_pkg::CELL_W'($urandom_range(0, 7)),
                      ffc_pkg::THR_W'($urandom_range(0, (1 << ffc_pkg::THR_W) - 1)));
      else
        queue_patch();
    end
  endtask

  task automatic queue_directed();
    queue_request(ffc_pkg::REQ_READ,   ROWS - 1, COLS - 1, ffc_pkg::CELL_YOUNG, '0);
    queue_request(ffc_pkg::REQ_WRITE,  0,        0,        CELL_BAD_B,  '0);  // refused write
    queue_request(ffc_pkg::REQ_WRITE,  0,        0,        CELL_BAD_A,  '0);
    queue_request(ffc_pkg::REQ_WRITE,  0,        1,        ffc_pkg::CELL_START, '0);
    queue_request(ffc_pkg::REQ_UPDATE, 0,        0,        ffc_pkg::CELL_YOUNG, '0);
    queue_request(ffc_pkg::REQ_UPDATE, 0,        0,        ffc_pkg::CELL_YOUNG, 17'd9999);
    queue_request(ffc_pkg::REQ_UPDATE, 0,        0,        ffc_pkg::CELL_YOUNG, 17'd10000);
    queue_request(ffc_pkg::REQ_WRITE,  31,       31,       ffc_pkg::CELL_BURN,  '0);
    queue_request(ffc_pkg::REQ_UPDATE, 32,       32,       ffc_pkg::CELL_YOUNG, 17'd19999);
    queue_request(ffc_pkg::REQ_WRITE,  31,       31,       ffc_pkg::CELL_END,   '0);
    queue_request(ffc_pkg::REQ_UPDATE, 30,       30,       ffc_pkg::CELL_YOUNG, 17'd9999);
    queue_request(ffc_pkg::REQ_UPDATE, ROWS - 1, COLS - 1, ffc_pkg::CELL_YOUNG, 17'd499);
    queue_request(ffc_pkg::REQ_UPDATE, ROWS - 1, COLS - 1, ffc_pkg::CELL_YOUNG, '0);
    queue_request(ffc_pkg::REQ_WRITE,  ROWS - 1, COLS - 1, ffc_pkg::CELL_ASHES, '0);
    queue_request(ffc_pkg::REQ_UPDATE, ROWS - 1, COLS - 1, ffc_pkg::CELL_YOUNG, 17'd199);
    queue_request(ffc_pkg::REQ_WRITE,  40,       40,       ffc_pkg::CELL_END,   '0);
    queue_request(ffc_pkg::REQ_UPDATE, 40,       40,       ffc_pkg::CELL_YOUNG, '1);
    queue_request(ffc_pkg::REQ_UPDATE, 40,       40,       ffc_pkg::CELL_YOUNG, '0);
    queue_request(REQ_SPARE,           40,       40,       ffc_pkg::CELL_ASHES, '1);
    queue_request(ffc_pkg::REQ_WRITE,  0,        COLS - 1, ffc_pkg::CELL_ASHES, '0);
    queue_request(ffc_pkg::REQ_WRITE,  ROWS - 1, 0,        ffc_pkg::CELL_MATURE, '0);
    queue_request(ffc_pkg::REQ_READ,   0,        COLS - 1, ffc_pkg::CELL_YOUNG, '0);
    queue_request(REQ_SPARE,           ROWS - 1, 0,        CELL_BAD_B,  '0);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || predicted_cells.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ffc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ffc_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // Phases 1..3 hold the extremes: never fire, always fire (dense min masked
  // to 15, so no self-ignition), scale top with all eight neighbours needed.
  task automatic program_phase(input int phase);
    logic [ffc_pkg::CFG_W-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case (phase)
        1:       v = '0;
        2:       v = '1;
        3:       v = ffc_pkg::CFG_W'(THR_SCALE);
        default: v = pick_threshold();
      endcase
      if (i == ffc_pkg::CFG_DENSE_MIN) begin
        case (phase)
          1:       v = '0;
          2:       v = '1;
          3:       v = ffc_pkg::CFG_W'(DENSE_ALL_NB);
          default: v = ffc_pkg::CFG_W'(($urandom_range(0, 8191) << 4) | $urandom_range(0, 9));
        endcase
      end
      write_reg(ffc_pkg::CFG_IDX_W'(i), v);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: advance to the next request once the current one is taken,
  // hold the payload while stalled.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    cell_req_t nxt;
    if (rst_n && (!in_valid || req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        nxt           = pending_requests.pop_front();
        in_valid     <= 1'b1;
        in_req_type  <= nxt.kind;
        in_row_index <= nxt.row;
        in_col_index <= nxt.col;
        in_new_state <= nxt.st;
        in_draw      <= nxt.draw;
        send_gap      = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure: bursts of stall with free cycles between them.
  always @(negedge clk) begin : drive_result_stall
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idling_on && $urandom_range(0, 2) == 0) hold_cycles = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict on each taken request, compare each
  // taken result against the oldest prediction, and watch for a hang.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    cell_req_t    rq;
    cell_result_t want;
    cell_result_t owed;
    logic         req_fire;
    logic         res_fire;
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++)
        for (int c = 0; c < COLS; c++) forest_model[r][c] = ffc_pkg::CELL_YOUNG;
      cfg_shadow[ffc_pkg::CFG_IGN_START] = ffc_pkg::RST_IGN_START;
      cfg_shadow[ffc_pkg::CFG_IGN_BURN]  = ffc_pkg::RST_IGN_BURN;
      cfg_shadow[ffc_pkg::CFG_IGN_END]   = ffc_pkg::RST_IGN_END;
      cfg_shadow[ffc_pkg::CFG_MATURE]    = ffc_pkg::RST_MATURE;
      cfg_shadow[ffc_pkg::CFG_SPONT]     = ffc_pkg::RST_SPONT;
      cfg_shadow[ffc_pkg::CFG_DENSE_MIN] =
        {{(ffc_pkg::CFG_W - ffc_pkg::DENSE_W){1'b0}}, ffc_pkg::RST_DENSE_MIN};
      cfg_shadow[ffc_pkg::CFG_BURN_PROG] = ffc_pkg::RST_BURN_PROG;
      cfg_shadow[ffc_pkg::CFG_REGROW]    = ffc_pkg::RST_REGROW;
      req_taken   = 1'b0;
      idle_cycles = 0;
    end else begin
      // Dense minimum keeps only its low bits.
      if (cfg_we)
        cfg_shadow[cfg_index] = (cfg_index == ffc_pkg::CFG_DENSE_MIN) ?
          {{(ffc_pkg::CFG_W - ffc_pkg::DENSE_W){1'b0}}, cfg_wdata[ffc_pkg::DENSE_W-1:0]} :
          cfg_wdata;
      req_fire  = in_valid && !in_stall;
      res_fire  = out_valid && !out_stall;
      req_taken = req_fire;
      if (req_fire) begin
        rq.kind = in_req_type;
        rq.row  = in_row_index;
        rq.col  = in_col_index;
        rq.st   = in_new_state;
        rq.draw = in_draw;
        owed    = step_cell_grid(rq);
        predicted_cells = {predicted_cells, owed};
      end
      if (res_fire) begin
        if (predicted_cells.size() == 0) begin
          err_count++;
          $display("%0t: result with no request outstanding: cell_state %0d changed %0b",
                   $time, out_cell_state, out_changed);
        end else begin
          want = predicted_cells.pop_front();
          if (out_cell_state !== want.state) begin
            err_count++;
            $display("%0t: cell_state mismatch: expected %0d actual %0d",
                     $time, want.state, out_cell_state);
          end
          if (out_changed !== want.changed) begin
            err_count++;
            $display("%0t: changed mismatch: expected %0b actual %0b",
                     $time, want.changed, out_changed);
          end
        end
      end
      if (req_fire || res_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no handshake for %0d cycles", $time, idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed requests on reset registers, then random phases,
  // each after the first with a fresh register set, some of them with no idling at all.
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_directed();
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        program_phase(phase);
      end
      idling_on = (phase % 3 != 1);
      fill_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[forest_fire_cell_update.f]
sv/ffc_pkg.sv
sv/forest_fire_cell_update.sv
tb/sv/tb_top.sv
